### rtl/core/slnx_pkg.sv
`default_nettype none
package slnx_pkg;

  localparam int SUM_W   = 44;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int FRAC_W  = 8;
  localparam int DIV_W   = SUM_W + FRAC_W;
  localparam int STEP_W  = $clog2(DIV_W + 1);
  localparam int MEAN_W  = 40;
  localparam int OUT_LEN_W = 32;
  localparam int OUT_CNT_W = 13;
  localparam int KIND_W  = 4;
  localparam int NUM_NX  = 9;

  localparam logic [KIND_W-1:0] KIND_SUMMARY = 4'd9;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic REG_MIN_LENGTH = 1'b0;
  localparam logic REG_IGNORE_NS  = 1'b1;

  typedef logic [DIV_W-1:0] dividend_t;

endpackage
`default_nettype wire

### rtl/core/sequence_length_nx_statistics_top.sv
`default_nettype none
// Sequence length Nx statistics.
// Command channel: an item is taken when start is high and busy is low.
// operation add stores one record length in the length memory and updates
// the running sums, so adds can arrive every cycle while busy is low. A
// length below min_length is ignored; one that finds the memory full is
// dropped and sets the overflow flag. operation finish raises busy and
// walks the stored lengths from the longest down. Each step of the walk is
// a full pass over the memory (one read a cycle) that finds the next
// smaller distinct length. The mean comes from a bit-serial divider of 52
// steps.
// Results: nine Nx words (kind 0..8) and a summary word (kind 9, last high),
// each shown for one cycle with valid; the receiver cannot stall them.
// An empty set gives nine zero Nx words and a zero summary.
// After the summary the sums, count and overflow flag are cleared.
// Reset (rst, synchronous) clears the sums and count, sets min_length
// to 1 and ignore_ns to 0; the length memory is not cleared.
// Configuration: cfg_write with cfg_index 0 (min_length) or 1 (ignore_ns).
module sequence_length_nx_statistics_top import slnx_pkg::*; #(
  parameter int MAX_SEQS    = 4096,
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 operation,
  input  wire logic [31:0]          seq_length,
  input  wire logic [31:0]          n_count,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      valid,
  output logic [KIND_W-1:0]         kind,
  output logic [OUT_LEN_W-1:0]      nx_length,
  output logic [OUT_CNT_W-1:0]      nx_count,
  output logic [SUM_W-1:0]          length_total,
  output logic [OUT_CNT_W-1:0]      number,
  output logic [MEAN_W-1:0]         mean,
  output logic [OUT_LEN_W-1:0]      longest,
  output logic [OUT_LEN_W-1:0]      shortest,
  output logic [SUM_W-1:0]          n_total,
  output logic                      overflow,
  output logic                      last
);

  localparam int LB     = LENGTH_BITS;
  localparam int ADDR_W = $clog2(MAX_SEQS);
  localparam int CNT_W  = $clog2(MAX_SEQS + 1);
  localparam int CUM_W  = LB + CNT_W;
  localparam int CMP_W  = (CUM_W + 4 > SUM_W + 4) ? CUM_W + 4 : SUM_W + 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMPTY = 3'd4;

  logic [LB-1:0] mem [MAX_SEQS];
  logic [LB-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  logic [31:0]       min_length;
  logic              ignore_ns;
  logic [CNT_W-1:0]  kept_count;
  logic [SUM_W-1:0]  length_sum;
  logic [SUM_W-1:0]  n_sum;
  logic              dropped_flag;
  logic [LB-1:0]     max_len;
  logic [LB-1:0]     min_len;

  logic [2:0]        state;

  // scan pass
  logic [CNT_W-1:0]  raddr;
  logic              pend;
  logic              pend_last;
  logic [LB-1:0]     cur;
  logic              cur_ok;
  logic [LB-1:0]     best;
  logic [CNT_W-1:0]  best_cnt;
  logic              have;
  logic [LB-1:0]     best_next;
  logic [CNT_W-1:0]  best_cnt_next;
  logic              have_next;

  // walk
  logic [LB-1:0]     gval;
  logic [CNT_W-1:0]  gcnt;
  logic              chk;
  logic [CUM_W-1:0]  cum;
  logic [CNT_W-1:0]  idx;
  logic [3:0]        k;
  logic [CMP_W-1:0]  thr;
  logic [CMP_W-1:0]  cum10;
  logic              reach;

  // add path
  logic [LB-1:0]     raw;
  logic [LB-1:0]     nc;
  logic [LB-1:0]     len;
  logic              keep;
  logic              full;
  logic [SUM_W:0]    lsum_add;
  logic [SUM_W:0]    nsum_add;

  logic              div_go;
  logic              div_done;
  dividend_t         quot;

  assign busy = (state != S_IDLE);

  assign raw  = LB'(seq_length);
  assign nc   = LB'(n_count);
  assign keep = 48'(raw) >= 48'(min_length);
  assign len  = ignore_ns ? ((nc > raw) ? '0 : raw - nc) : raw;
  assign full = kept_count >= CNT_W'(MAX_SEQS);
  assign lsum_add = (SUM_W+1)'(length_sum) + (SUM_W+1)'(len);
  assign nsum_add = (SUM_W+1)'(n_sum) + (SUM_W+1)'(nc);

  // length memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && operation == OP_ADD && keep && !full) begin
      mem[kept_count[ADDR_W-1:0]] <= len;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_en   = (state == S_SCAN) && (raddr < kept_count);
  assign rd_addr = raddr[ADDR_W-1:0];

  // next-smaller-distinct search over the word coming back from memory
  always_comb begin
    best_next     = best;
    best_cnt_next = best_cnt;
    have_next     = have;
    if (pend && (!cur_ok || rd_data < cur)) begin
      if (!have || rd_data > best) begin
        best_next     = rd_data;
        best_cnt_next = CNT_W'(1);
        have_next     = 1'b1;
      end else if (rd_data == best) begin
        best_cnt_next = best_cnt + CNT_W'(1);
      end
    end
  end

  assign cum10 = (CMP_W'(cum) << 3) + (CMP_W'(cum) << 1);
  assign reach = (k < 4'(NUM_NX)) && (cum10 >= thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      min_length   <= 32'd1;
      ignore_ns    <= 1'b0;
      kept_count   <= '0;
      length_sum   <= '0;
      n_sum        <= '0;
      dropped_flag <= 1'b0;
      valid        <= 1'b0;
      div_go       <= 1'b0;
      pend         <= 1'b0;
    end else begin
      valid  <= 1'b0;
      div_go <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == REG_MIN_LENGTH) min_length <= cfg_data;
        else ignore_ns <= cfg_data[0];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (operation == OP_ADD) begin
              if (keep) begin
                if (full) begin
                  dropped_flag <= 1'b1;
                end else begin
                  kept_count <= kept_count + CNT_W'(1);
                  length_sum <= lsum_add > (SUM_W+1)'(SUM_MAX) ? SUM_MAX
                                                               : SUM_W'(lsum_add);
                  n_sum      <= nsum_add > (SUM_W+1)'(SUM_MAX) ? SUM_MAX
                                                               : SUM_W'(nsum_add);
                  if (kept_count == '0 || len > max_len) max_len <= len;
                  if (kept_count == '0 || len < min_len) min_len <= len;
                end
              end
            end else begin
              k <= '0;
              if (kept_count == '0) begin
                state <= S_EMPTY;
              end else begin
                state  <= S_SCAN;
                raddr  <= '0;
                pend   <= 1'b0;
                have   <= 1'b0;
                cur_ok <= 1'b0;
                cum    <= '0;
                idx    <= '0;
                thr    <= CMP_W'(length_sum);
              end
            end
          end
        end
        S_SCAN: begin
          if (raddr < kept_count) raddr <= raddr + CNT_W'(1);
          pend      <= raddr < kept_count;
          pend_last <= raddr == kept_count - CNT_W'(1);
          best      <= best_next;
          best_cnt  <= best_cnt_next;
          have      <= have_next;
          if (pend && pend_last) begin
            state <= S_WALK;
            gval  <= best_next;
            gcnt  <= best_cnt_next;
            cur   <= best_next;
            chk   <= 1'b0;
          end
        end
        S_WALK: begin
          if (!chk) begin
            cum  <= cum + CUM_W'(gval);
            idx  <= idx + CNT_W'(1);
            gcnt <= gcnt - CNT_W'(1);
            chk  <= 1'b1;
          end else if (reach) begin
            valid     <= 1'b1;
            kind      <= KIND_W'(k);
            nx_length <= OUT_LEN_W'(gval);
            nx_count  <= OUT_CNT_W'(idx);
            length_total <= '0;
            number    <= '0;
            mean      <= '0;
            longest   <= '0;
            shortest  <= '0;
            n_total   <= '0;
            overflow  <= 1'b0;
            last      <= 1'b0;
            k         <= k + 4'd1;
            thr       <= thr + CMP_W'(length_sum);
          end else begin
            chk <= 1'b0;
            if (k == 4'(NUM_NX)) begin
              state  <= S_DIV;
              div_go <= 1'b1;
            end else if (gcnt == '0) begin
              // next group of equal lengths
              state  <= S_SCAN;
              raddr  <= '0;
              pend   <= 1'b0;
              have   <= 1'b0;
              cur_ok <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            valid        <= 1'b1;
            kind         <= KIND_SUMMARY;
            nx_length    <= '0;
            nx_count     <= '0;
            length_total <= length_sum;
            number       <= OUT_CNT_W'(kept_count);
            mean         <= quot[MEAN_W-1:0];
            longest      <= OUT_LEN_W'(max_len);
            shortest     <= OUT_LEN_W'(min_len);
            n_total      <= n_sum;
            overflow     <= dropped_flag;
            last         <= 1'b1;
            kept_count   <= '0;
            length_sum   <= '0;
            n_sum        <= '0;
            dropped_flag <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_EMPTY: begin
          valid        <= 1'b1;
          nx_length    <= '0;
          nx_count     <= '0;
          length_total <= '0;
          number       <= '0;
          mean         <= '0;
          longest      <= '0;
          shortest     <= '0;
          n_total      <= '0;
          overflow     <= 1'b0;
          if (k == 4'(NUM_NX)) begin
            kind         <= KIND_SUMMARY;
            last         <= 1'b1;
            dropped_flag <= 1'b0;
            state        <= S_IDLE;
          end else begin
            kind <= KIND_W'(k);
            last <= 1'b0;
            k    <= k + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  slnx_div #(
    .DIVISOR_BITS(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend ({length_sum, FRAC_W'(0)}),
    .divisor  (kept_count),
    .done     (div_done),
    .quotient (quot)
  );

endmodule
`default_nettype wire

### rtl/core/slnx_div.sv
`default_nettype none
module slnx_div import slnx_pkg::*; #(
  parameter int DIVISOR_BITS = 13
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    go,
  input  wire dividend_t               dividend,
  input  wire logic [DIVISOR_BITS-1:0] divisor,
  output logic                         done,
  output dividend_t                    quotient
);

  logic [DIVISOR_BITS-1:0] rem;
  logic [STEP_W-1:0]       cnt;
  logic                    running;
  logic [DIVISOR_BITS:0]   trial;
  logic                    fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running  <= 1'b1;
        cnt      <= STEP_W'(DIV_W);
        quotient <= dividend;
        rem      <= '0;
      end else if (running) begin
        quotient <= {quotient[DIV_W-2:0], fits};
        rem      <= fits ? DIVISOR_BITS'(trial - {1'b0, divisor})
                         : DIVISOR_BITS'(trial);
        cnt      <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
